@@ design/abid_pkg.sv @@
// Shared kinds, match constants and result type for the branch instruction decoder.
package abid_pkg;

    localparam int unsigned IMM_W  = 33;
    localparam int unsigned ADDR_W = 64;

    localparam logic [3:0] KIND_UNKNOWN = 4'd0;
    localparam logic [3:0] KIND_B       = 4'd1;
    localparam logic [3:0] KIND_BL      = 4'd2;
    localparam logic [3:0] KIND_BR      = 4'd3;
    localparam logic [3:0] KIND_BLR     = 4'd4;
    localparam logic [3:0] KIND_ADRP    = 4'd5;
    localparam logic [3:0] KIND_ADD     = 4'd6;
    localparam logic [3:0] KIND_LDRLIT  = 4'd7;
    localparam logic [3:0] KIND_RET     = 4'd8;

    localparam logic [31:0] OP_B        = 32'h1400_0000;
    localparam logic [31:0] OP_BL       = 32'h9400_0000;
    localparam logic [31:0] OP_BR       = 32'hD61F_0000;
    localparam logic [31:0] OP_BLR      = 32'hD63F_0000;
    localparam logic [31:0] OP_ADRP     = 32'h9000_0000;
    localparam logic [31:0] OP_LDRLIT   = 32'h5800_0000;
    localparam logic [31:0] OP_ADD      = 32'h9100_0000;
    localparam logic [31:0] OP_RET      = 32'hD65F_0000;
    localparam logic [31:0] A32_BRANCH  = 32'h0A00_0000;
    localparam logic [31:0] MASK_REGBR  = 32'hFFFF_FC1F;
    localparam logic [31:0] MASK_BIMM   = 32'hFC00_0000;
    localparam logic [31:0] MASK_ADRP   = 32'h9F00_0000;
    localparam logic [31:0] MASK_TOP8   = 32'hFF00_0000;

    localparam logic [IMM_W-1:0] A32_PC_OFS = 33'd8;

    typedef struct packed {
        logic [3:0]        kind;
        logic [4:0]        dest_reg;
        logic [4:0]        base_reg;
        logic [IMM_W-1:0]  immediate;
        logic [ADDR_W-1:0] target_address;
        logic              target_valid;
    } t_result;

endpackage

@@ design/abid_decode.sv @@
// Combinational decode of one instruction word into kind, registers, immediate and target.
module abid_decode (
    input  logic                        i_isa_mode,
    input  logic [31:0]                 i_word,
    input  logic [abid_pkg::ADDR_W-1:0] i_address,
    output abid_pkg::t_result           o_result
);

    logic [3:0]                  kind;
    logic [4:0]                  rd;
    logic [4:0]                  rn;
    logic [abid_pkg::IMM_W-1:0]  imm;
    logic [abid_pkg::IMM_W-1:0]  addend;
    logic [abid_pkg::ADDR_W-1:0] base;
    logic                        has_tgt;
    logic                        valid;
    logic [abid_pkg::ADDR_W-1:0] tgt;

    always_comb begin
        kind    = abid_pkg::KIND_UNKNOWN;
        rd      = 5'd0;
        rn      = 5'd0;
        imm     = '0;
        addend  = '0;
        base    = i_address;
        has_tgt = 1'b0;
        valid   = 1'b0;
        if (i_isa_mode) begin
            // condition field ignored
            if ((i_word & abid_pkg::A32_BRANCH) == abid_pkg::A32_BRANCH) begin
                kind    = abid_pkg::KIND_B;
                imm     = {{7{i_word[23]}}, i_word[23:0], 2'b00};
                addend  = imm + abid_pkg::A32_PC_OFS;
                has_tgt = 1'b1;
                valid   = 1'b1;
            end
        end else if ((i_word & abid_pkg::MASK_BIMM) == abid_pkg::OP_B
                  || (i_word & abid_pkg::MASK_BIMM) == abid_pkg::OP_BL) begin
            kind    = i_word[31] ? abid_pkg::KIND_BL : abid_pkg::KIND_B;
            imm     = {{5{i_word[25]}}, i_word[25:0], 2'b00};
            addend  = imm;
            has_tgt = 1'b1;
            valid   = 1'b1;
        end else if ((i_word & abid_pkg::MASK_REGBR) == abid_pkg::OP_BR) begin
            kind = abid_pkg::KIND_BR;
            rn   = i_word[9:5];
        end else if ((i_word & abid_pkg::MASK_REGBR) == abid_pkg::OP_BLR) begin
            kind = abid_pkg::KIND_BLR;
            rn   = i_word[9:5];
        end else if ((i_word & abid_pkg::MASK_ADRP) == abid_pkg::OP_ADRP) begin
            kind    = abid_pkg::KIND_ADRP;
            rd      = i_word[4:0];
            imm     = {i_word[23:5], i_word[30:29], 12'h000};
            addend  = imm;
            base    = {i_address[abid_pkg::ADDR_W-1:12], 12'h000};
            has_tgt = 1'b1;
        end else if ((i_word & abid_pkg::MASK_TOP8) == abid_pkg::OP_LDRLIT) begin
            kind    = abid_pkg::KIND_LDRLIT;
            rd      = i_word[4:0];
            imm     = {{12{i_word[23]}}, i_word[23:5], 2'b00};
            addend  = imm;
            has_tgt = 1'b1;
        end else if ((i_word & abid_pkg::MASK_TOP8) == abid_pkg::OP_ADD) begin
            kind = abid_pkg::KIND_ADD;
            rd   = i_word[4:0];
            rn   = i_word[9:5];
            imm  = i_word[22] ? {9'd0, i_word[21:10], 12'h000} : {21'd0, i_word[21:10]};
        end else if ((i_word & abid_pkg::MASK_REGBR) == abid_pkg::OP_RET) begin
            kind = abid_pkg::KIND_RET;
            rn   = i_word[9:5];
        end
    end

    // Wraps at 64 bits.
    assign tgt = has_tgt
        ? base + {{(abid_pkg::ADDR_W-abid_pkg::IMM_W){addend[abid_pkg::IMM_W-1]}}, addend}
        : '0;

    assign o_result.kind           = kind;
    assign o_result.dest_reg       = rd;
    assign o_result.base_reg       = rn;
    assign o_result.immediate      = imm;
    assign o_result.target_address = tgt;
    assign o_result.target_valid   = valid;

endmodule

@@ design/arm64_branch_insn_decoder.sv @@
// Top level of the AArch64 / ARMv7 branch instruction decoder.
//
// Input channel: i_in_valid / o_in_ready carry one instruction word and its
// address per item. Output channel: o_out_valid / i_out_ready carry the
// decoded kind, registers, byte immediate and target address.
// The item is registered on entry, decoded by one pass of logic whose
// longest path is the 64-bit target add, and registered at the output.
// o_out_valid rises once an accepted item has moved from the input register into the
// result register; throughput is one item per cycle while i_out_ready stays high.
// A stalled receiver holds the result register; the input register keeps
// taking items until it is also full, then o_in_ready drops.
// i_cfg_we writes isa_mode (0 AArch64, 1 ARMv7) from i_cfg_wdata.
// Synchronous active-low reset empties both stages and sets isa_mode to 0.
module arm64_branch_insn_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_insn_word,
    input  logic [63:0] i_insn_address,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_insn_kind,
    output logic [4:0]  o_dest_reg,
    output logic [4:0]  o_base_reg,
    output logic [32:0] o_immediate,
    output logic [63:0] o_target_address,
    output logic        o_target_valid
);

    logic                        r_isa_mode;
    logic                        r_in_valid;
    logic [31:0]                 r_word;
    logic [abid_pkg::ADDR_W-1:0] r_address;
    logic                        r_out_valid;
    abid_pkg::t_result           r_out;
    abid_pkg::t_result           n_out;
    logic                        out_load;
    logic                        in_load;

    assign out_load   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || out_load;
    assign in_load    = i_in_valid && o_in_ready;

    abid_decode u_decode (
        .i_isa_mode (r_isa_mode),
        .i_word     (r_word),
        .i_address  (r_address),
        .o_result   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_isa_mode  <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_isa_mode <= i_cfg_wdata;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_word    <= i_insn_word;
            r_address <= i_insn_address;
        end
        // advance only a real item into the result register
        if (out_load && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_insn_kind      = r_out.kind;
    assign o_dest_reg       = r_out.dest_reg;
    assign o_base_reg       = r_out.base_reg;
    assign o_immediate      = r_out.immediate;
    assign o_target_address = r_out.target_address;
    assign o_target_valid   = r_out.target_valid;

endmodule
